// ===== hdl/lmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types and constants for the LED matrix frame scan block.
// ----------------------------------------------------------------------------
package lmfs_pkg;

    // bits held per frame column, bit r is the pixel in row r
    localparam int FRAME_BITS = 8;

    // operation codes on the command channel
    localparam logic [1:0] OP_PLOT  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    // one-hot seed for the pixel mask of a plot
    localparam logic [FRAME_BITS-1:0] PIXEL_SEED = 8'h01;

    // control group from the sequencer to the frame memory
    typedef struct packed {
        logic rd_en;   // read the addressed column
        logic wr_en;   // write the addressed column
        logic clr;     // blank the whole frame
    } ram_ctl_t;

endpackage

// ===== hdl/lmfs_if.sv =====
// ----------------------------------------------------------------------------
// lmfs_if
// Valid/ready channels of the LED matrix frame scan block: the command
// channel and the serial bit channel.
// ----------------------------------------------------------------------------
interface lmfs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [3:0] col_x;
    logic [3:0] row_y;
    logic       pixel_on;
    logic [2:0] scan_row;

    modport source (output valid, op, col_x, row_y, pixel_on, scan_row, input ready);
    modport sink   (input valid, op, col_x, row_y, pixel_on, scan_row, output ready);
endinterface

interface lmfs_bit_if;
    logic       valid;
    logic       ready;
    logic       serial_bit;
    logic [4:0] bit_position;
    logic       latch_after;

    modport source (output valid, serial_bit, bit_position, latch_after, input ready);
    modport sink   (input valid, serial_bit, bit_position, latch_after, output ready);
endinterface

// ===== hdl/lmfs_frame_ram.sv =====
// ----------------------------------------------------------------------------
// lmfs_frame_ram
// Frame column memory with registered read. Per-column valid bits make a
// blank frame after reset or a clear without a sweep.
// ----------------------------------------------------------------------------
module lmfs_frame_ram #(
    parameter int COLUMNS = 15,
    parameter int AW      = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lmfs_pkg::ram_ctl_t                 ctl,
    input  logic [AW-1:0]                      addr,
    input  logic [lmfs_pkg::FRAME_BITS-1:0]    wdata,
    output logic [lmfs_pkg::FRAME_BITS-1:0]    rdata
);

    logic [lmfs_pkg::FRAME_BITS-1:0] mem [COLUMNS];
    logic [COLUMNS-1:0]              vld_reg;
    logic [lmfs_pkg::FRAME_BITS-1:0] rd_word_reg;
    logic                            rd_vld_reg;

    // column storage
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_word_reg <= mem[addr];
        end
    end

    // written marks, cleared by reset and by a frame clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[addr];
            end
        end
    end

    // unwritten columns read as dark
    assign rdata = rd_vld_reg ? rd_word_reg : '0;

endmodule

// ===== hdl/lmfs_out_reg.sv =====
// ----------------------------------------------------------------------------
// lmfs_out_reg
// Output register of the serial bit channel; decouples the scan pipeline
// from downstream stalls.
// ----------------------------------------------------------------------------
module lmfs_out_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       serial_bit,
    input  logic [4:0] bit_position,
    input  logic       latch_after,
    output logic       can_load,
    lmfs_bit_if.source ser
);

    logic       valid_reg;
    logic       bit_reg;
    logic [4:0] pos_reg;
    logic       latch_reg;

    // free when empty or when the held word leaves this cycle
    assign can_load = !valid_reg || ser.ready;

    // word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // word payload
    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            bit_reg   <= serial_bit;
            pos_reg   <= bit_position;
            latch_reg <= latch_after;
        end
    end

    assign ser.valid        = valid_reg;
    assign ser.serial_bit   = bit_reg;
    assign ser.bit_position = pos_reg;
    assign ser.latch_after  = latch_reg;

endmodule

// ===== hdl/led_matrix_frame_scan.sv =====
// ----------------------------------------------------------------------------
// led_matrix_frame_scan
// Frame buffer for a COLUMNS x ROWS monochrome LED matrix with serial
// row scan-out for a shift register chain.
// ----------------------------------------------------------------------------
// A scan command produces COLUMNS+ROWS serial words (23 by default), one per
// cycle while the output is taken: the column bits from the highest column
// down, then the one-hot row select with the highest row first, the last
// word flagged with latch_after. The frame memory is read one column per
// cycle while the output is taken, through a registered read, so a scan
// holds the block from the accepting cycle until the last word is loaded,
// output stalls included. A plot is a read-modify-write of one column: a
// read, then a write; a clear needs no sweep. Plots outside the frame and
// unused op codes are dropped.
// The next command is taken once the last scan word sits in the output
// register; that word may still be waiting downstream.
// ----------------------------------------------------------------------------
module led_matrix_frame_scan #(
    parameter int COLUMNS = 15,
    parameter int ROWS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    lmfs_cmd_if.sink    cmd,
    lmfs_bit_if.source  ser
);

    localparam int TOTAL = COLUMNS + ROWS;
    localparam int PW    = $clog2(TOTAL + 1);
    localparam int AW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLOT_WR,
        ST_SCAN
    } state_t;

    state_t                          state_reg, state_next;
    logic [PW-1:0]                   idx_reg, idx_next;
    logic [2:0]                      row_reg, row_next;
    logic                            p1_valid_reg, p1_valid_next;
    logic [PW-1:0]                   p1_pos_reg, p1_pos_next;
    logic [AW-1:0]                   plot_addr_reg, plot_addr_next;
    logic [lmfs_pkg::FRAME_BITS-1:0] plot_mask_reg, plot_mask_next;
    logic                            plot_on_reg, plot_on_next;

    lmfs_pkg::ram_ctl_t              ram_ctl;
    logic [AW-1:0]                   ram_addr;
    logic [lmfs_pkg::FRAME_BITS-1:0] ram_wdata;
    logic [lmfs_pkg::FRAME_BITS-1:0] ram_rdata;

    logic                            cmd_fire;
    logic                            plot_hit;
    logic                            issue;
    logic                            out_load;
    logic                            can_load;
    logic [PW-1:0]                   scan_col;
    logic [PW-1:0]                   sel_row;
    logic                            word_bit;
    logic                            word_latch;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign plot_hit  = (32'(cmd.col_x) < COLUMNS) && (32'(cmd.row_y) < ROWS);

    // scan pipeline: read stage feeds the output register
    assign out_load = p1_valid_reg && can_load;
    assign issue    = (state_reg == ST_SCAN) && (idx_reg != PW'(TOTAL))
                      && (!p1_valid_reg || out_load);
    assign scan_col = PW'(COLUMNS - 1) - idx_reg;

    // word formed from the read stage
    assign sel_row    = PW'(TOTAL - 1) - p1_pos_reg;
    assign word_bit   = (p1_pos_reg < PW'(COLUMNS)) ? ram_rdata[row_reg]
                        : (32'(row_reg) == 32'(sel_row));
    assign word_latch = (p1_pos_reg == PW'(TOTAL - 1));

    // next-state and memory control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        p1_valid_next  = p1_valid_reg;
        p1_pos_next    = p1_pos_reg;
        plot_addr_next = plot_addr_reg;
        plot_mask_next = plot_mask_reg;
        plot_on_next   = plot_on_reg;
        ram_ctl        = '0;
        ram_addr       = plot_addr_reg;
        ram_wdata      = plot_on_reg ? (ram_rdata | plot_mask_reg)
                                     : (ram_rdata & ~plot_mask_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.op)
                        lmfs_pkg::OP_PLOT:
                        begin
                            if (plot_hit)
                            begin
                                ram_ctl.rd_en  = 1'b1;
                                ram_addr       = AW'(cmd.col_x);
                                plot_addr_next = AW'(cmd.col_x);
                                plot_mask_next = lmfs_pkg::PIXEL_SEED << cmd.row_y[2:0];
                                plot_on_next   = cmd.pixel_on;
                                state_next     = ST_PLOT_WR;
                            end
                        end
                        lmfs_pkg::OP_CLEAR:
                        begin
                            ram_ctl.clr = 1'b1;
                        end
                        lmfs_pkg::OP_SCAN:
                        begin
                            row_next   = cmd.scan_row;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PLOT_WR:
            begin
                ram_ctl.wr_en = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (out_load)
                begin
                    p1_valid_next = 1'b0;
                end
                if (issue)
                begin
                    ram_ctl.rd_en = (idx_reg < PW'(COLUMNS));
                    ram_addr      = scan_col[AW-1:0];
                    p1_valid_next = 1'b1;
                    p1_pos_next   = idx_reg;
                    idx_next      = idx_reg + PW'(1);
                end
                if ((idx_reg == PW'(TOTAL)) && (!p1_valid_reg || out_load))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            row_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p1_pos_reg    <= '0;
            plot_addr_reg <= '0;
            plot_mask_reg <= '0;
            plot_on_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            p1_valid_reg  <= p1_valid_next;
            p1_pos_reg    <= p1_pos_next;
            plot_addr_reg <= plot_addr_next;
            plot_mask_reg <= plot_mask_next;
            plot_on_reg   <= plot_on_next;
        end
    end

    lmfs_frame_ram #(
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    lmfs_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .serial_bit   (word_bit),
        .bit_position (5'(p1_pos_reg)),
        .latch_after  (word_latch),
        .can_load     (can_load),
        .ser          (ser)
    );

    // a new command never overlaps a word still in the read stage
    a_cmd_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |-> !p1_valid_reg)
        else $error("command accepted with scan word in flight");

    // scan index never runs past the end of the stream
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= PW'(TOTAL)))
        else $error("scan index beyond stream length");

    // the latch word is the last one the read stage holds
    a_latch_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && word_latch) |=> (!p1_valid_reg && state_reg == ST_IDLE))
        else $error("scan continued after latch word");

    // a column write always follows its read in the previous cycle
    a_plot_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.wr_en |-> ($past(ram_ctl.rd_en) && $past(state_reg == ST_IDLE)))
        else $error("column write without preceding read");

endmodule
